// ----- rtl/core/gpg_pkg.sv -----
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared constants, codes and sideband types of the gradient pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gpg_pkg;

  // fraction format: Q1.FRAC_BITS in T_W bits, ONE = 2^FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  // frame dimensions
  localparam int DIM_W = 9;
  localparam logic [DIM_W-1:0] DIM_MAX = 9'd256;

  // divider: dividend < divisor, quotient has 2*FRAC_BITS bits
  localparam int DIV_W         = 20;
  localparam int QUO_W         = 2 * FRAC_BITS;
  localparam int DIV_PER_STAGE = 4;

  // square root: steps per pipeline stage
  localparam int SQ_PER_STAGE = 4;
  localparam int SQ_REM_W     = FRAC_BITS + 4;

  // ramp direction codes
  localparam logic [2:0] DIR_HORZ   = 3'd0;
  localparam logic [2:0] DIR_VERT   = 3'd1;
  localparam logic [2:0] DIR_DIAG_D = 3'd2;
  localparam logic [2:0] DIR_DIAG_U = 3'd3;
  localparam logic [2:0] DIR_RADIAL = 3'd4;

  // register indexes
  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_END    = 3'd1;
  localparam logic [2:0] REG_DIR    = 3'd2;
  localparam logic [2:0] REG_BRIGHT = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  typedef struct packed {
    logic radial;
    logic sat_one;
  } div_tag_t;

  typedef struct packed {
    logic                 radial;
    logic                 sat_one;
    logic [FRAC_BITS-1:0] lin_t;
  } sq_tag_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpg_divider.sv -----
// ----------------------------------------------------------------------------
// gpg_divider
// Pipelined restoring divider: quo = floor(num * 2^QUO_W / den), num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_vld,
  input  wire logic [gpg_pkg::DIV_W-1:0]    num,
  input  wire logic [gpg_pkg::DIV_W-1:0]    den,
  input  wire gpg_pkg::div_tag_t            in_tag,
  output logic                              out_vld,
  output logic [gpg_pkg::QUO_W-1:0]         quo,
  output gpg_pkg::div_tag_t                 out_tag
);

  localparam int NSTG = gpg_pkg::QUO_W / gpg_pkg::DIV_PER_STAGE;

  logic [NSTG:0]                 vld;
  logic [gpg_pkg::DIV_W-1:0]     rem_r [NSTG+1];
  logic [gpg_pkg::DIV_W-1:0]     den_r [NSTG+1];
  logic [gpg_pkg::QUO_W-1:0]     quo_r [NSTG+1];
  gpg_pkg::div_tag_t             tag_r [NSTG+1];

  assign vld[0]   = in_vld;
  assign rem_r[0] = num;
  assign den_r[0] = den;
  assign quo_r[0] = '0;
  assign tag_r[0] = in_tag;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [gpg_pkg::DIV_W-1:0] rem_next;
    logic [gpg_pkg::QUO_W-1:0] quo_next;

    always_comb begin
      rem_next = rem_r[s];
      quo_next = quo_r[s];
      for (int k = 0; k < gpg_pkg::DIV_PER_STAGE; k++) begin
        rem_next = {rem_next[gpg_pkg::DIV_W-2:0], 1'b0};
        quo_next = {quo_next[gpg_pkg::QUO_W-2:0], 1'b0};
        if (rem_next >= den_r[s]) begin
          rem_next    = rem_next - den_r[s];
          quo_next[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem_r[s+1] <= rem_next;
      quo_r[s+1] <= quo_next;
      den_r[s+1] <= den_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_vld = vld[NSTG];
  assign quo     = quo_r[NSTG];
  assign out_tag = tag_r[NSTG];

endmodule

`default_nettype wire

// ----- rtl/core/gpg_isqrt.sv -----
// ----------------------------------------------------------------------------
// gpg_isqrt
// Pipelined digit-by-digit integer square root of a QUO_W-bit operand.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_vld,
  input  wire logic [gpg_pkg::QUO_W-1:0]     rad,
  input  wire gpg_pkg::sq_tag_t              in_tag,
  output logic                               out_vld,
  output logic [gpg_pkg::FRAC_BITS-1:0]      root,
  output gpg_pkg::sq_tag_t                   out_tag
);

  localparam int NSTG = gpg_pkg::FRAC_BITS / gpg_pkg::SQ_PER_STAGE;
  localparam int RW   = gpg_pkg::SQ_REM_W;
  localparam int QW   = gpg_pkg::QUO_W;
  localparam int FW   = gpg_pkg::FRAC_BITS;

  logic [NSTG:0]      vld;
  logic [QW-1:0]      rad_r  [NSTG+1];
  logic [RW-1:0]      rem_r  [NSTG+1];
  logic [FW-1:0]      root_r [NSTG+1];
  gpg_pkg::sq_tag_t   tag_r  [NSTG+1];

  assign vld[0]    = in_vld;
  assign rad_r[0]  = rad;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign tag_r[0]  = in_tag;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [QW-1:0] rad_next;
    logic [RW-1:0] rem_next;
    logic [FW-1:0] root_next;
    logic [RW-1:0] trial;

    always_comb begin
      rad_next  = rad_r[s];
      rem_next  = rem_r[s];
      root_next = root_r[s];
      trial     = '0;
      for (int k = 0; k < gpg_pkg::SQ_PER_STAGE; k++) begin
        rem_next = {rem_next[RW-3:0], rad_next[QW-1 -: 2]};
        rad_next = {rad_next[QW-3:0], 2'b00};
        trial    = RW'({root_next, 2'b01});
        if (rem_next >= trial) begin
          rem_next  = rem_next - trial;
          root_next = {root_next[FW-2:0], 1'b1};
        end else begin
          root_next = {root_next[FW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rad_r[s+1]  <= rad_next;
      rem_r[s+1]  <= rem_next;
      root_r[s+1] <= root_next;
      tag_r[s+1]  <= tag_r[s];
    end
  end

  assign out_vld = vld[NSTG];
  assign root    = root_r[NSTG];
  assign out_tag = tag_r[NSTG];

endmodule

`default_nettype wire

// ----- rtl/core/gradient_pixel_generator_unit.sv -----
// ----------------------------------------------------------------------------
// gradient_pixel_generator_unit
// Two-color linear or radial gradient, one RGB pixel per clock.
// ----------------------------------------------------------------------------
// One pixel is taken on every clock where start is high; busy is always low.
// Each pixel's color appears on red/green/blue with valid high for a single
// cycle, in order, one per clock. The pipeline holds two setup stages, the
// 32-step fraction divider (8 stages of 4 steps), the 16-step square root
// (4 stages of 4 steps), one interpolation stage and one brightness stage.
// Results cannot be held off, so the receiver must take each one in the
// cycle it is shown.
// Registers sit on an APB-style port; write them only with no pixels in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_pixel_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // pixel transaction
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  col,
  input  wire logic [7:0]  row,
  // result transaction
  output logic             valid,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int FW  = gpg_pkg::FRAC_BITS;
  localparam int TW  = gpg_pkg::T_W;
  localparam int DW  = gpg_pkg::DIV_W;
  localparam int DMW = gpg_pkg::DIM_W;
  localparam int LAT = 4 + gpg_pkg::QUO_W / gpg_pkg::DIV_PER_STAGE
                         + gpg_pkg::FRAC_BITS / gpg_pkg::SQ_PER_STAGE;

  // --------------------------------------------------------------------------
  // Register file
  // --------------------------------------------------------------------------
  logic [23:0]    start_color;
  logic [23:0]    end_color;
  logic [2:0]     ramp_direction;
  logic [DMW-1:0] brightness;
  logic [DMW-1:0] frame_width;
  logic [DMW-1:0] frame_height;
  logic           wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color    <= 24'h000000;
      end_color      <= 24'hFFFFFF;
      ramp_direction <= gpg_pkg::DIR_HORZ;
      brightness     <= 9'd256;
      frame_width    <= 9'd64;
      frame_height   <= 9'd64;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        gpg_pkg::REG_START:  start_color    <= pwdata[23:0];
        gpg_pkg::REG_END:    end_color      <= pwdata[23:0];
        gpg_pkg::REG_DIR:    ramp_direction <= pwdata[2:0];
        gpg_pkg::REG_BRIGHT: brightness     <= pwdata[DMW-1:0];
        gpg_pkg::REG_WIDTH:  frame_width    <= pwdata[DMW-1:0];
        gpg_pkg::REG_HEIGHT: frame_height   <= pwdata[DMW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gpg_pkg::REG_START:  prdata = {8'd0, start_color};
      gpg_pkg::REG_END:    prdata = {8'd0, end_color};
      gpg_pkg::REG_DIR:    prdata = {29'd0, ramp_direction};
      gpg_pkg::REG_BRIGHT: prdata = {23'd0, brightness};
      gpg_pkg::REG_WIDTH:  prdata = {23'd0, frame_width};
      gpg_pkg::REG_HEIGHT: prdata = {23'd0, frame_height};
      default:             prdata = '0;
    endcase
  end

  // frame size clamped to [1, DIM_MAX]; brightness clamped to full
  logic [DMW-1:0] w_sat;
  logic [DMW-1:0] h_sat;
  logic [DMW-1:0] br_sat;

  always_comb begin
    w_sat = frame_width;
    if (frame_width == '0) w_sat = DMW'(1);
    else if (frame_width > gpg_pkg::DIM_MAX) w_sat = gpg_pkg::DIM_MAX;
    h_sat = frame_height;
    if (frame_height == '0) h_sat = DMW'(1);
    else if (frame_height > gpg_pkg::DIM_MAX) h_sat = gpg_pkg::DIM_MAX;
    br_sat = brightness[8] ? 9'd256 : brightness;
  end

  // --------------------------------------------------------------------------
  // Stage 1: numerator/denominator of the linear ramps, centered offsets
  // --------------------------------------------------------------------------
  logic               s1_vld;
  logic [2:0]         s1_dir;
  logic signed [10:0] s1_num;
  logic [9:0]         s1_den;
  logic signed [10:0] s1_a;
  logic signed [10:0] s1_b;
  logic [DMW-1:0]     s1_w;
  logic [DMW-1:0]     s1_h;

  logic signed [10:0] num_c;
  logic [9:0]         den_c;

  always_comb begin
    case (ramp_direction)
      gpg_pkg::DIR_HORZ: begin
        num_c = $signed({3'd0, col});
        den_c = {1'b0, w_sat} - 10'd1;
      end
      gpg_pkg::DIR_VERT: begin
        num_c = $signed({3'd0, row});
        den_c = {1'b0, h_sat} - 10'd1;
      end
      gpg_pkg::DIR_DIAG_D: begin
        num_c = $signed({3'd0, col}) + $signed({3'd0, row});
        den_c = {1'b0, w_sat} + {1'b0, h_sat} - 10'd2;
      end
      gpg_pkg::DIR_DIAG_U: begin
        // negative when the row exceeds col + h_sat - 1
        num_c = $signed({3'd0, col}) + $signed({2'd0, h_sat}) - 11'sd1
              - $signed({3'd0, row});
        den_c = {1'b0, w_sat} + {1'b0, h_sat} - 10'd2;
      end
      default: begin
        num_c = '0;
        den_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
    s1_dir <= ramp_direction;
    s1_num <= num_c;
    s1_den <= den_c;
    s1_a   <= $signed({2'd0, col, 1'b0}) - $signed({2'd0, w_sat});
    s1_b   <= $signed({2'd0, row, 1'b0}) - $signed({2'd0, h_sat});
    s1_w   <= w_sat;
    s1_h   <= h_sat;
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared distance, pick dividend/divisor, flag saturations
  // --------------------------------------------------------------------------
  logic signed [21:0] sq_a;
  logic signed [21:0] sq_b;
  logic [DW-1:0]      dsq;
  logic [DW-1:0]      diag;
  logic [DW-1:0]      n_c;
  logic [DW-1:0]      d_c;
  logic               zero_c;
  gpg_pkg::div_tag_t  tag_c;

  always_comb begin
    sq_a   = s1_a * s1_a;
    sq_b   = s1_b * s1_b;
    dsq    = sq_a[DW-1:0] + sq_b[DW-1:0];
    diag   = DW'(s1_w) * DW'(s1_w) + DW'(s1_h) * DW'(s1_h);
    n_c    = '0;
    d_c    = '0;
    zero_c = 1'b1;
    tag_c  = '{radial: 1'b0, sat_one: 1'b0};
    case (s1_dir)
      gpg_pkg::DIR_HORZ, gpg_pkg::DIR_VERT,
      gpg_pkg::DIR_DIAG_D, gpg_pkg::DIR_DIAG_U: begin
        n_c    = DW'(s1_num[9:0]);
        d_c    = DW'(s1_den);
        zero_c = (s1_num <= 11'sd0) || (s1_den == '0);
      end
      gpg_pkg::DIR_RADIAL: begin
        n_c          = dsq;
        d_c          = diag;
        zero_c       = 1'b0;
        tag_c.radial = 1'b1;
      end
      default: ;
    endcase
    tag_c.sat_one = ~zero_c && (n_c >= d_c);
  end

  logic              s2_vld;
  logic [DW-1:0]     s2_num;
  logic [DW-1:0]     s2_den;
  gpg_pkg::div_tag_t s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    // saturated or zero cases divide 0 by a safe divisor
    s2_num <= (zero_c || tag_c.sat_one) ? '0 : n_c;
    s2_den <= (d_c == '0) ? DW'(1) : d_c;
    s2_tag <= tag_c;
  end

  // --------------------------------------------------------------------------
  // Fraction divider and square root
  // --------------------------------------------------------------------------
  logic                       dv_vld;
  logic [gpg_pkg::QUO_W-1:0]  dv_quo;
  gpg_pkg::div_tag_t          dv_tag;
  gpg_pkg::sq_tag_t           sq_in_tag;

  gpg_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s2_vld),
    .num     (s2_num),
    .den     (s2_den),
    .in_tag  (s2_tag),
    .out_vld (dv_vld),
    .quo     (dv_quo),
    .out_tag (dv_tag)
  );

  // linear ramps need only the upper half of the quotient
  assign sq_in_tag = '{radial:  dv_tag.radial,
                       sat_one: dv_tag.sat_one,
                       lin_t:   dv_quo[gpg_pkg::QUO_W-1 -: FW]};

  logic              sq_vld;
  logic [FW-1:0]     sq_root;
  gpg_pkg::sq_tag_t  sq_tag;

  gpg_isqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (dv_vld),
    .rad     (dv_quo),
    .in_tag  (sq_in_tag),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_tag (sq_tag)
  );

  // --------------------------------------------------------------------------
  // Interpolation stage: lc = (c1*ONE + (c2-c1)*t) >> FRAC_BITS
  // --------------------------------------------------------------------------
  logic [TW-1:0]      t_sel;
  logic [7:0]         lc_c [3];
  logic               li_vld;
  logic [7:0]         li_lc [3];

  always_comb begin
    logic [7:0]         c1;
    logic [7:0]         c2;
    logic signed [8:0]  diff;
    logic signed [26:0] prod;
    logic signed [26:0] v;
    if (sq_tag.sat_one) t_sel = gpg_pkg::T_ONE;
    else if (sq_tag.radial) t_sel = TW'(sq_root);
    else t_sel = TW'(sq_tag.lin_t);
    for (int ch = 0; ch < 3; ch++) begin
      c1   = start_color[16 - 8*ch +: 8];
      c2   = end_color[16 - 8*ch +: 8];
      diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
      prod = 27'(diff) * 27'($signed({1'b0, t_sel}));
      v    = $signed(27'({c1, FW'(0)})) + prod;
      lc_c[ch] = v[FW +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      li_vld <= 1'b0;
    end else begin
      li_vld <= sq_vld;
    end
    li_lc <= lc_c;
  end

  // --------------------------------------------------------------------------
  // Brightness stage: out = (lc * br) >> 8
  // --------------------------------------------------------------------------
  logic [16:0] sc [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sc[ch] = li_lc[ch] * br_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= li_vld;
    end
    red   <= sc[0][15:8];
    green <= sc[1][15:8];
    blue  <= sc[2][15:8];
  end

`ifndef NO_ASSERTIONS
  // every result traces back to an earlier pixel taken on start
  a_latency: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start, LAT))
    else $error("result without matching pixel transaction");

  // zero brightness blanks the pixel
  a_dark: assert property (@(posedge clk) disable iff (rst)
    (valid && brightness == '0) |-> (red == '0 && green == '0 && blue == '0))
    else $error("nonzero pixel at zero brightness");

  // a flat gradient at full brightness returns the start color
  a_flat: assert property (@(posedge clk) disable iff (rst)
    (valid && start_color == end_color && br_sat == 9'd256)
      |-> (red == start_color[23:16] && green == start_color[15:8]
           && blue == start_color[7:0]))
    else $error("flat gradient mismatch");
`endif

endmodule

`default_nettype wire

// ----- sim/gpg_checker.sv -----
// ----------------------------------------------------------------------------
// gpg_checker
// Watches pixel and result transactions, predicts each pixel's color from a
// shadow copy of the registers and compares results in order.
// ----------------------------------------------------------------------------
module gpg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  col,
  input  logic [7:0]  row,
  input  logic        valid,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] sh_start, sh_end;
  logic [2:0]  sh_dir;
  logic [8:0]  sh_bright, sh_width, sh_height;
  logic [23:0] color_q[$];

  function automatic logic [16:0] lin_t(longint num, longint den);
    longint q;
    if (den <= 0 || num <= 0) return 17'd0;
    q = (num * 65536) / den;
    return (q > 65536) ? 17'h10000 : 17'(q);
  endfunction

  function automatic logic [16:0] radial_t(longint x, longint y, longint w, longint h);
    longint a, b, d, m, q, r, bitv;
    a = 2 * x - w;
    b = 2 * y - h;
    d = a * a + b * b;
    m = w * w + h * h;
    if (d >= m) return 17'h10000;
    q = (d * 64'd4294967296) / m;   // d < 2^18, fits
    r = 0;
    bitv = 64'd1 << 40;
    while (bitv > q) bitv >>= 2;
    while (bitv != 0) begin
      if (q >= r + bitv) begin
        q -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return (r > 65536) ? 17'h10000 : 17'(r);
  endfunction

  function automatic logic [23:0] pixel_color(logic [7:0] x, logic [7:0] y);
    longint w, h, br, t, c1, c2, v;
    logic [23:0] rgb;
    w = (sh_width == 0) ? 1 : (sh_width > 256) ? 256 : sh_width;
    h = (sh_height == 0) ? 1 : (sh_height > 256) ? 256 : sh_height;
    br = (sh_bright > 256) ? 256 : sh_bright;
    case (sh_dir)
      gpg_pkg::DIR_HORZ:   t = lin_t(x, w - 1);
      gpg_pkg::DIR_VERT:   t = lin_t(y, h - 1);
      gpg_pkg::DIR_DIAG_D: t = lin_t(x + y, w + h - 2);
      gpg_pkg::DIR_DIAG_U: t = lin_t(x + h - 1 - y, w + h - 2);
      gpg_pkg::DIR_RADIAL: t = radial_t(x, y, w, h);
      default:             t = 0;
    endcase
    for (int s = 0; s < 3; s++) begin
      c1 = (sh_start >> (16 - 8 * s)) & 8'hFF;
      c2 = (sh_end >> (16 - 8 * s)) & 8'hFF;
      v = (c1 * 65536 + (c2 - c1) * t) >>> 16;
      rgb[16 - 8 * s +: 8] = 8'((v * br) >> 8);
    end
    return rgb;
  endfunction

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      sh_start <= 24'h0; sh_end <= 24'hFFFFFF; sh_dir <= gpg_pkg::DIR_HORZ;
      sh_bright <= 9'd256; sh_width <= 9'd64; sh_height <= 9'd64;
      color_q.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) color_q.push_back(pixel_color(col, row));
      if (valid) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected result %h%h%h", $time, red, green, blue);
          fail_count <= fail_count + 1;
        end else begin
          want = color_q.pop_front();
          if (want !== {red, green, blue}) begin
            $display("%0t: color mismatch expected %h actual %h%h%h",
                     $time, want, red, green, blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          gpg_pkg::REG_START:  sh_start  <= pwdata[23:0];
          gpg_pkg::REG_END:    sh_end    <= pwdata[23:0];
          gpg_pkg::REG_DIR:    sh_dir    <= pwdata[2:0];
          gpg_pkg::REG_BRIGHT: sh_bright <= pwdata[8:0];
          gpg_pkg::REG_WIDTH:  sh_width  <= pwdata[8:0];
          gpg_pkg::REG_HEIGHT: sh_height <= pwdata[8:0];
          default: ;
        endcase
      end
    end
    pending <= color_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel transactions and register writes into the gradient generator
// over several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16;
  localparam int LIMIT   = 400000;

  logic clk = 1'b0, rst = 1'b1;
  logic start = 1'b0;
  logic [7:0] col = 8'd0, row = 8'd0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic busy, valid, pready;
  logic [7:0] red, green, blue;
  logic [31:0] prdata;
  int fail_count, pending;
  int cycles = 0;

  gradient_pixel_generator_unit dut (.*);
  gpg_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[gradient_pixel_generator_unit] ERROR");
      $finish;
    end
  end

  // register write: setup then access phase
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until all results are back, plus pipeline drain
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_all(logic [23:0] c0, logic [23:0] c1, logic [2:0] dir,
                         logic [8:0] br, logic [8:0] w, logic [8:0] h);
    drain();
    reg_write(gpg_pkg::REG_START, {8'h0, c0});
    reg_write(gpg_pkg::REG_END, {8'h0, c1});
    reg_write(gpg_pkg::REG_DIR, {29'h0, dir});
    reg_write(gpg_pkg::REG_BRIGHT, {23'h0, br});
    reg_write(gpg_pkg::REG_WIDTH, {23'h0, w});
    reg_write(gpg_pkg::REG_HEIGHT, {23'h0, h});
  endtask

  // one pixel transaction, with an optional gap before it
  task automatic send_pixel(logic [7:0] x, logic [7:0] y, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1; col <= x; row <= y;
    do @(posedge clk); while (busy);
  endtask

  // random pixel, mostly inside the frame
  task automatic rand_pixel(int w, int h, bit gaps);
    logic [7:0] x, y;
    if ($urandom_range(0, 4) != 0) begin
      x = 8'($urandom_range(0, w - 1));
      y = 8'($urandom_range(0, h - 1));
    end else begin
      x = 8'($urandom); y = 8'($urandom);
    end
    send_pixel(x, y, gaps);
  endtask

  initial begin
    logic [8:0] w, h;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, corners and outside-frame pixels
    send_pixel(8'd0, 8'd0, 0);
    send_pixel(8'd63, 8'd63, 0);
    send_pixel(8'd255, 8'd255, 0);
    start <= 1'b0;
    // every direction, including unknown codes, at the frame corners and past the frame
    for (int d = 0; d < 8; d++) begin
      set_all(24'h123456, 24'hFEDCBA, 3'(d), 9'd256, 9'd16, 9'd8);
      send_pixel(8'd0, 8'd0, 0);
      send_pixel(8'd15, 8'd7, 0);
      send_pixel(8'd3, 8'd200, 0);   // row past frame: negative numerator going up
      start <= 1'b0;
    end
    // size one frame (zero divisor), zero height, oversize, bright past full
    set_all(24'hFFFFFF, 24'h000000, gpg_pkg::DIR_DIAG_D, 9'd511, 9'd1, 9'd0);
    send_pixel(8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd128, 0);
    start <= 1'b0;
    set_all(24'hFF00FF, 24'h00FF00, gpg_pkg::DIR_RADIAL, 9'd0, 9'd511, 9'd256);
    send_pixel(8'd128, 8'd128, 0);
    send_pixel(8'd255, 8'd0, 0);
    start <= 1'b0;

    // random phases
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin w = 9'd256; h = 9'd256; end
        1: begin w = 9'd1; h = 9'd2; end
        default: begin w = 9'($urandom_range(1, 256)); h = 9'($urandom_range(1, 256)); end
      endcase
      set_all(24'($urandom), 24'($urandom),
              (ph < 10) ? 3'(ph % 5) : 3'($urandom),
              (ph == 3) ? 9'd0 : 9'($urandom_range(0, 300)), w, h);
      for (int i = 0; i < 48; i++) begin
        rand_pixel(w, h, ph != 2);   // phase 2 back-to-back
        if (i == 20 && ph == 5) begin
          start <= 1'b0;
          do @(posedge clk); while (pending != 0);
        end
      end
      start <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("[gradient_pixel_generator_unit] OK");
    end else begin
      $display("[gradient_pixel_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
